// ===== hdl/hse_pkg.sv =====
`timescale 1ns / 1ps
// hse_pkg: word types and fixed widths shared by the heap sort engine
// no dependencies; used by hse_pick and heap_sort_engine

package hse_pkg;

  localparam int KEY_W    = 32;  // width of the key field on both channels
  localparam int ORIGIN_W = 6;   // width of the arrival index field

  // input word: one key per word, last_element closes the set
  typedef struct packed {
    logic signed [KEY_W-1:0] sort_key;
    logic                    last_element;
  } in_word_t;

  // output word: one sorted entry per word
  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic [ORIGIN_W-1:0]     origin_index;
    logic                    final_result;
    logic                    items_dropped;
  } out_word_t;

  // outcome of one sift step compare
  typedef struct packed {
    logic take_left;   // left child outranks the parent
    logic take_right;  // right child outranks the better of the two
  } pick_t;

endpackage

// ===== hdl/hse_pick.sv =====
`timescale 1ns / 1ps
// hse_pick: shared compare unit of one sift-down step (parent vs two children)
// depends on hse_pkg for pick_t

module hse_pick #(
  parameter int KEY_BITS = 32
) (
  input  logic                descending,
  input  logic [KEY_BITS-1:0] cur_key,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic                right_ok,
  output hse_pkg::pick_t      pick
);

  logic [KEY_BITS-1:0] best_key;

  // strict rank of a over b, signed order flipped when descending
  function automatic logic ranks_above(input logic [KEY_BITS-1:0] a,
                                       input logic [KEY_BITS-1:0] b,
                                       input logic desc);
    logic [KEY_BITS-1:0] ua;
    logic [KEY_BITS-1:0] ub;
    ua = a ^ {1'b1, {(KEY_BITS-1){1'b0}}};
    ub = b ^ {1'b1, {(KEY_BITS-1){1'b0}}};
    return desc ? (ua < ub) : (ua > ub);
  endfunction

  always_comb begin
    pick.take_left  = ranks_above(left_key, cur_key, descending);
    best_key        = pick.take_left ? left_key : cur_key;
    pick.take_right = right_ok && ranks_above(right_key, best_key, descending);
  end

endmodule

// ===== hdl/heap_sort_engine.sv =====
`timescale 1ns / 1ps
// heap_sort_engine: heapsort of a set of signed keys with arrival indexes
// depends on hse_pkg (word types) and hse_pick (sift compare unit)

// Usage
//   input channel: in_valid / in_stall / in_word. one key per word; the word
//     with last_element set closes the set and starts the sort. words beyond
//     MAX_ITEMS are dropped and every result of that set shows items_dropped.
//   output channel: out_valid / out_stall / out_word. one word per stored
//     key, ascending (descending when sort_descending is set), each with its
//     arrival index; the last word of the set has final_result set.
//   config: cfg_write loads cfg_data into sort_descending; write it only idle.
// Timing
//   loading takes one word per cycle. after the closing word, in_stall stays
//   high until the last result is taken. sorting runs on one key memory with
//   two registered read ports and one write port under a sequencer: each
//   sift-down reads its top entry, fetches its children, then moves one heap
//   level per memory write until the held entry is put into the hole.
//   out_valid drops after each taken result before the next one is shown;
//   while out_stall is high the output word is held unchanged.
// Reset
//   rst (synchronous) empties the set, clears the drop flag and the
//   descending bit; memory contents are not cleared and need not be.

module heap_sort_engine #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hse_pkg::in_word_t     in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hse_pkg::out_word_t    out_word,
  input  logic                  cfg_write,
  input  logic                  cfg_data
);

  localparam int ADDR_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W   = ADDR_W + 2;   // holds child indexes up to 2*MAX_ITEMS
  localparam int STATE_W = 4;

  // sequencer states
  localparam logic [STATE_W-1:0] S_LOAD      = 4'd0;
  localparam logic [STATE_W-1:0] S_BUILD     = 4'd1;
  localparam logic [STATE_W-1:0] S_SIFT_TOP  = 4'd2;
  localparam logic [STATE_W-1:0] S_SIFT_CMP  = 4'd3;
  localparam logic [STATE_W-1:0] S_SIFT_PUT  = 4'd4;
  localparam logic [STATE_W-1:0] S_EXTRACT   = 4'd5;
  localparam logic [STATE_W-1:0] S_SWAP      = 4'd6;
  localparam logic [STATE_W-1:0] S_EMIT_RD   = 4'd7;
  localparam logic [STATE_W-1:0] S_EMIT_HOLD = 4'd8;

  // key and arrival index memories
  logic [KEY_BITS-1:0]         key_mem [MAX_ITEMS];
  logic [hse_pkg::ORIGIN_W-1:0] idx_mem [MAX_ITEMS];

  // control registers
  logic [STATE_W-1:0] state, state_next;
  logic [CNT_W-1:0]   loaded_count, loaded_count_next;
  logic               overflow_seen, overflow_seen_next;
  logic               sort_descending;
  logic [CNT_W-1:0]   heap_n, heap_n_next;       // size of the heap being sifted
  logic [CNT_W-1:0]   outer, outer_next;         // build / extract loop counter
  logic [ADDR_W-1:0]  node, node_next;           // current hole of the sift
  logic [ADDR_W-1:0]  emit_pos, emit_pos_next;
  logic               building, building_next;
  logic               out_valid_r, out_valid_next;

  // payload registers
  logic [KEY_BITS-1:0]          cur_key, cur_key_next;
  logic [hse_pkg::ORIGIN_W-1:0] cur_idx, cur_idx_next;
  logic [KEY_BITS-1:0]          rd_key_a, rd_key_b;
  logic [hse_pkg::ORIGIN_W-1:0] rd_idx_a, rd_idx_b;
  hse_pkg::out_word_t           out_word_r, out_word_next;

  // memory port controls
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_wa;
  logic [KEY_BITS-1:0]          mem_wkey;
  logic [hse_pkg::ORIGIN_W-1:0] mem_widx;
  logic [ADDR_W-1:0]            ra_a, ra_b;

  // datapath helpers
  hse_pkg::pick_t               pick;
  logic [KEY_BITS+hse_pkg::KEY_W-1:0] in_key_wide;
  logic [KEY_BITS+hse_pkg::KEY_W-1:0] out_key_wide;
  logic [CNT_W+hse_pkg::ORIGIN_W-1:0] arrival_wide;
  logic [IDX_W-1:0]             left_x, right_x, best_x, down_left_x;
  logic [IDX_W-1:0]             heap_n_x, outer_x;
  logic                         has_room;
  logic                         in_take;
  logic                         out_take;

  hse_pick #(
    .KEY_BITS (KEY_BITS)
  ) u_pick (
    .descending (sort_descending),
    .cur_key    (cur_key),
    .left_key   (rd_key_a),
    .right_key  (rd_key_b),
    .right_ok   (right_x < heap_n_x),
    .pick       (pick)
  );

  assign in_stall  = (state != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  // key width adaption: input taken as 32 bits, stored at KEY_BITS
  assign in_key_wide  = {{KEY_BITS{1'b0}}, in_word.sort_key};
  assign out_key_wide = {{hse_pkg::KEY_W{1'b0}}, rd_key_a};
  assign arrival_wide = {{hse_pkg::ORIGIN_W{1'b0}}, loaded_count};

  assign has_room    = (loaded_count < CNT_W'(MAX_ITEMS));
  assign heap_n_x    = IDX_W'(heap_n);
  assign outer_x     = IDX_W'(outer);
  assign left_x      = (IDX_W'(node) << 1) + IDX_W'(1);
  assign right_x     = left_x + IDX_W'(1);
  assign best_x      = pick.take_right ? right_x : (pick.take_left ? left_x : IDX_W'(node));
  assign down_left_x = (best_x << 1) + IDX_W'(1);

  // sequencer
  always_comb begin
    state_next         = state;
    loaded_count_next  = loaded_count;
    overflow_seen_next = overflow_seen;
    heap_n_next        = heap_n;
    outer_next         = outer;
    node_next          = node;
    emit_pos_next      = emit_pos;
    building_next      = building;
    out_valid_next     = out_valid_r;
    cur_key_next       = cur_key;
    cur_idx_next       = cur_idx;
    out_word_next      = out_word_r;
    mem_we             = 1'b0;
    mem_wa             = node;
    mem_wkey           = cur_key;
    mem_widx           = cur_idx;
    ra_a               = '0;
    ra_b               = '0;

    case (state)
      S_LOAD: begin
        if (in_take) begin
          if (has_room) begin
            mem_we            = 1'b1;
            mem_wa            = loaded_count[ADDR_W-1:0];
            mem_wkey          = in_key_wide[KEY_BITS-1:0];
            mem_widx          = arrival_wide[hse_pkg::ORIGIN_W-1:0];
            loaded_count_next = loaded_count + CNT_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
          if (in_word.last_element) begin
            outer_next    = (has_room ? loaded_count + CNT_W'(1) : loaded_count) >> 1;
            building_next = 1'b1;
            state_next    = S_BUILD;
          end
        end
      end

      // heapify: sift down each inner node from the middle to the root
      S_BUILD: begin
        if (outer == '0) begin
          outer_next    = loaded_count;
          building_next = 1'b0;
          state_next    = S_EXTRACT;
        end else begin
          ra_a        = outer_x[ADDR_W-1:0] - ADDR_W'(1);
          node_next   = outer_x[ADDR_W-1:0] - ADDR_W'(1);
          heap_n_next = loaded_count;
          outer_next  = outer - CNT_W'(1);
          state_next  = S_SIFT_TOP;
        end
      end

      // sift start: hold the top entry, fetch its children
      S_SIFT_TOP: begin
        cur_key_next = rd_key_a;
        cur_idx_next = rd_idx_a;
        if (left_x < heap_n_x) begin
          ra_a       = left_x[ADDR_W-1:0];
          ra_b       = right_x[ADDR_W-1:0];
          state_next = S_SIFT_CMP;
        end else begin
          state_next = building ? S_BUILD : S_EXTRACT;
        end
      end

      // one heap level per cycle: hole gets the better child, or the held entry
      S_SIFT_CMP: begin
        mem_we = 1'b1;
        if (!pick.take_left && !pick.take_right) begin
          state_next = building ? S_BUILD : S_EXTRACT;
        end else begin
          mem_wkey  = pick.take_right ? rd_key_b : rd_key_a;
          mem_widx  = pick.take_right ? rd_idx_b : rd_idx_a;
          node_next = best_x[ADDR_W-1:0];
          if (down_left_x < heap_n_x) begin
            ra_a = down_left_x[ADDR_W-1:0];
            ra_b = down_left_x[ADDR_W-1:0] + ADDR_W'(1);
          end else begin
            state_next = S_SIFT_PUT;
          end
        end
      end

      S_SIFT_PUT: begin
        mem_we     = 1'b1;
        state_next = building ? S_BUILD : S_EXTRACT;
      end

      // extraction: root goes to the end of the unsorted part
      S_EXTRACT: begin
        if (outer == '0) begin
          emit_pos_next = '0;
          state_next    = S_EMIT_RD;
        end else begin
          ra_b       = outer_x[ADDR_W-1:0] - ADDR_W'(1);
          state_next = S_SWAP;
        end
      end

      S_SWAP: begin
        mem_we       = 1'b1;
        mem_wa       = outer_x[ADDR_W-1:0] - ADDR_W'(1);
        mem_wkey     = rd_key_a;
        mem_widx     = rd_idx_a;
        cur_key_next = rd_key_b;
        cur_idx_next = rd_idx_b;
        heap_n_next  = outer - CNT_W'(1);
        outer_next   = outer - CNT_W'(1);
        node_next    = '0;
        if (outer > CNT_W'(2)) begin
          ra_a       = ADDR_W'(1);
          ra_b       = ADDR_W'(2);
          state_next = S_SIFT_CMP;
        end else begin
          state_next = S_SIFT_PUT;
        end
      end

      // output: the read address was issued in the cycle before
      S_EMIT_RD: begin
        out_word_next.sorted_key    = signed'(out_key_wide[hse_pkg::KEY_W-1:0]);
        out_word_next.origin_index  = rd_idx_a;
        out_word_next.final_result  = (IDX_W'(emit_pos) + IDX_W'(1) == IDX_W'(loaded_count));
        out_word_next.items_dropped = overflow_seen;
        out_valid_next              = 1'b1;
        state_next                  = S_EMIT_HOLD;
      end

      S_EMIT_HOLD: begin
        ra_a = emit_pos + ADDR_W'(1);
        if (out_take) begin
          out_valid_next = 1'b0;
          if (out_word_r.final_result) begin
            loaded_count_next  = '0;
            overflow_seen_next = 1'b0;
            state_next         = S_LOAD;
          end else begin
            emit_pos_next = emit_pos + ADDR_W'(1);
            state_next    = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      loaded_count    <= '0;
      overflow_seen   <= 1'b0;
      sort_descending <= 1'b0;
      heap_n          <= '0;
      outer           <= '0;
      node            <= '0;
      emit_pos        <= '0;
      building        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state         <= state_next;
      loaded_count  <= loaded_count_next;
      overflow_seen <= overflow_seen_next;
      heap_n        <= heap_n_next;
      outer         <= outer_next;
      node          <= node_next;
      emit_pos      <= emit_pos_next;
      building      <= building_next;
      out_valid_r   <= out_valid_next;
      if (cfg_write) begin
        sort_descending <= cfg_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cur_key    <= cur_key_next;
    cur_idx    <= cur_idx_next;
    out_word_r <= out_word_next;
  end

  // memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wkey;
      idx_mem[mem_wa] <= mem_widx;
    end
    rd_key_a <= key_mem[ra_a];
    rd_idx_a <= idx_mem[ra_a];
    rd_key_b <= key_mem[ra_b];
    rd_idx_b <= idx_mem[ra_b];
  end

endmodule
